[sv/esdr_pkg.sv]
package esdr_pkg;

  // Kind of input transaction, carried on s_axis_tuser
  typedef enum logic [1:0] {
    ACT_PIN_A = 2'd0,
    ACT_PIN_B = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Encoder arming flags
  typedef struct packed {
    logic ccw;
    logic cw;
  } arm_t;

  localparam int unsigned SCALE_W     = 12;
  localparam int unsigned MEAS_W      = 16;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [SCALE_W-1:0]    SCALE_RESET    = 12'd1000;
  localparam int unsigned           DRIVE_RESET    = 600;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SCALE     = 2'd0;

endpackage

[sv/esdr_step.sv]
module esdr_step
  import esdr_pkg::*;
#(
  parameter int unsigned DAC_BITS      = 12,
  parameter int unsigned SETPOINT_BITS = 8
) (
  input  action_e                   action_i,
  input  logic                      pin_a_i,
  input  logic                      pin_b_i,
  input  logic [MEAS_W-1:0]         meas_i,
  input  logic [SCALE_W-1:0]        scale_i,
  input  arm_t                      arm_i,
  input  logic [SETPOINT_BITS-1:0]  setpoint_i,
  input  logic [DAC_BITS-1:0]       drive_i,
  output arm_t                      arm_o,
  output logic [SETPOINT_BITS-1:0]  setpoint_o,
  output logic [DAC_BITS-1:0]       drive_o
);

  localparam int unsigned ProdW = SETPOINT_BITS + SCALE_W;
  localparam logic [SETPOINT_BITS-1:0] SpMax = '1;
  localparam logic [DAC_BITS-1:0]      DacMax = '1;

  logic [ProdW-1:0] target;
  logic [ProdW-1:0] meas_ext;
  logic             below;
  logic             above;

  assign target   = ProdW'(setpoint_i) * ProdW'(scale_i);
  assign meas_ext = ProdW'(meas_i);
  assign below    = meas_ext < target;
  assign above    = meas_ext > target;

  always_comb begin
    arm_o      = arm_i;
    setpoint_o = setpoint_i;
    drive_o    = drive_i;
    unique case (action_i)
      ACT_PIN_A: begin
        if (!pin_a_i && pin_b_i) begin
          arm_o.ccw = 1'b1;
        end
        // detent complete: step down, saturate at zero
        if (arm_i.cw && !pin_a_i && !pin_b_i) begin
          arm_o = '0;
          if (setpoint_i != '0) begin
            setpoint_o = setpoint_i - SETPOINT_BITS'(1);
          end
        end
      end
      ACT_PIN_B: begin
        if (pin_a_i && !pin_b_i) begin
          arm_o.cw = 1'b1;
        end
        if (arm_i.ccw && !pin_a_i && !pin_b_i) begin
          arm_o = '0;
          if (setpoint_i != SpMax) begin
            setpoint_o = setpoint_i + SETPOINT_BITS'(1);
          end
        end
      end
      ACT_TICK: begin
        if (below && drive_i != DacMax) begin
          drive_o = drive_i + DAC_BITS'(1);
        end else if (above && drive_i != '0) begin
          drive_o = drive_i - DAC_BITS'(1);
        end
        if (setpoint_i == '0) begin
          drive_o = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/encoder_setpoint_dac_step_regulator_top.sv]
// Encoder-set current regulator. Each input transaction is an encoder edge
// (tuser 0: pin A, 1: pin B) or a control tick (tuser 2) with the measured
// current in mA; every transaction gives exactly one result carrying the DAC
// drive code and the setpoint after the update. Encoder detents step the
// setpoint up or down, saturating at its range; a tick moves the drive code
// one step towards setpoint * setpoint_scale_ma (APB register at address 0,
// reset 1000) and forces it to zero while the setpoint is zero. The drive
// code comes out of reset at 600. One transaction is accepted every cycle
// while the output is not stalled; the input register loads at the accepting
// edge and the state/result register when that transaction advances.
// A stalled output holds the input stage too.
module encoder_setpoint_dac_step_regulator_top
  import esdr_pkg::*;
#(
  parameter int unsigned DAC_BITS      = 12,
  parameter int unsigned SETPOINT_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] pin_a_level, [1] pin_b_level, [17:2] measured_ma, [23:18] zero
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [ACTION_W-1:0]    s_axis_tuser,
  // master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [DAC_BITS-1:0] dac_code, then setpoint_steps, zero padding above
  output logic [((DAC_BITS+SETPOINT_BITS+7)/8)*8-1:0] m_axis_tdata,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned OutW = ((DAC_BITS + SETPOINT_BITS + 7) / 8) * 8;
  localparam logic [DAC_BITS-1:0] DriveReset = DAC_BITS'(DRIVE_RESET);

  logic [SCALE_W-1:0]       scale_q;

  logic                     in_valid_q;
  action_e                  in_action_q;
  logic                     in_a_q;
  logic                     in_b_q;
  logic [MEAS_W-1:0]        in_meas_q;

  logic                     out_valid_q;
  logic                     out_valid_d;
  arm_t                     arm_q;
  arm_t                     arm_d;
  logic [SETPOINT_BITS-1:0] sp_q;
  logic [SETPOINT_BITS-1:0] sp_d;
  logic [DAC_BITS-1:0]      drive_q;
  logic [DAC_BITS-1:0]      drive_d;

  logic                     advance;
  logic                     in_take;
  logic                     cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_SCALE);
  assign prdata = (paddr == ADDR_SCALE) ? CFG_DATA_W'(scale_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_wr) begin
      scale_q <= pwdata[SCALE_W-1:0];
    end
  end

  // handshake: the state registers double as the result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({sp_q, drive_q});

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= action_e'(s_axis_tuser);
      in_a_q      <= s_axis_tdata[0];
      in_b_q      <= s_axis_tdata[1];
      in_meas_q   <= s_axis_tdata[MEAS_W+1:2];
    end
  end

  esdr_step #(
    .DAC_BITS      (DAC_BITS),
    .SETPOINT_BITS (SETPOINT_BITS)
  ) u_step (
    .action_i   (in_action_q),
    .pin_a_i    (in_a_q),
    .pin_b_i    (in_b_q),
    .meas_i     (in_meas_q),
    .scale_i    (scale_q),
    .arm_i      (arm_q),
    .setpoint_i (sp_q),
    .drive_i    (drive_q),
    .arm_o      (arm_d),
    .setpoint_o (sp_d),
    .drive_o    (drive_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      arm_q       <= '0;
      sp_q        <= '0;
      drive_q     <= DriveReset;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        arm_q   <= arm_d;
        sp_q    <= sp_d;
        drive_q <= drive_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_free_out_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while result register empty");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed transaction produced no result");

  a_setpoint_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (sp_q == $past(sp_q) || sp_q == $past(sp_q) + SETPOINT_BITS'(1)
                 || sp_q == $past(sp_q) - SETPOINT_BITS'(1)))
    else $error("setpoint moved by more than one step");

  a_drive_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (drive_q == '0 || drive_q == $past(drive_q)
                 || drive_q == $past(drive_q) + DAC_BITS'(1)
                 || drive_q == $past(drive_q) - DAC_BITS'(1)))
    else $error("drive code jumped");
`endif

endmodule

[tb/tb_encoder_setpoint_dac_step_regulator_top.sv]
`timescale 1ns / 100ps

module tb_encoder_setpoint_dac_step_regulator_top;
  import esdr_pkg::*;

  localparam int unsigned DAC_W        = 12;
  localparam int unsigned SP_W         = 8;
  localparam int unsigned OUT_W        = ((DAC_W + SP_W + 7) / 8) * 8;
  localparam int unsigned DAC_TOP      = (1 << DAC_W) - 1;
  localparam int unsigned SP_TOP       = (1 << SP_W) - 1;
  localparam int unsigned MEAS_TOP     = (1 << MEAS_W) - 1;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [DAC_W-1:0] dac;
    logic [SP_W-1:0]  setpoint;
  } reading_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [ACTION_W-1:0]   s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  encoder_setpoint_dac_step_regulator_top #(
    .DAC_BITS     (DAC_W),
    .SETPOINT_BITS(SP_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Regulator state as the block should hold it
  logic             ccw_arm_m   = 1'b0;
  logic             cw_arm_m    = 1'b0;
  logic [SP_W-1:0]  setpoint_m  = '0;
  logic [DAC_W-1:0] drive_m     = DAC_W'(DRIVE_RESET);
  logic [SCALE_W-1:0] scale_m   = SCALE_RESET;

  reading_t pending_readings[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int items_taken;
  int readings_seen;
  int scale_writes;
  int readbacks;
  int mismatches;

  function automatic void bump_setpoint(input logic up);
    ccw_arm_m = 1'b0;
    cw_arm_m  = 1'b0;
    if (up) begin
      if (setpoint_m != SP_W'(SP_TOP)) setpoint_m = setpoint_m + 1'b1;
    end else begin
      if (setpoint_m != '0) setpoint_m = setpoint_m - 1'b1;
    end
  endfunction

  function automatic reading_t advance_regulator(input action_e act, input logic pin_a,
                                                 input logic pin_b,
                                                 input logic [MEAS_W-1:0] ma);
    logic [19:0] target_ma;
    reading_t r;
    case (act)
      ACT_PIN_A: begin
        if (!ccw_arm_m && !pin_a && pin_b) ccw_arm_m = 1'b1;
        if (cw_arm_m && !pin_a && !pin_b) bump_setpoint(1'b0);
      end
      ACT_PIN_B: begin
        if (!cw_arm_m && pin_a && !pin_b) cw_arm_m = 1'b1;
        if (ccw_arm_m && !pin_a && !pin_b) bump_setpoint(1'b1);
      end
      ACT_TICK: begin
        target_ma = 20'(setpoint_m) * 20'(scale_m);
        if (20'(ma) < target_ma) begin
          if (drive_m != DAC_W'(DAC_TOP)) drive_m = drive_m + 1'b1;
        end else if (20'(ma) > target_ma) begin
          if (drive_m != '0) drive_m = drive_m - 1'b1;
        end
        if (setpoint_m == '0) drive_m = '0;
      end
      default: ;
    endcase
    r.dac      = drive_m;
    r.setpoint = setpoint_m;
    return r;
  endfunction

  // Predict on every accepted input transaction and every register write
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_readings.push_back(advance_regulator(action_e'(s_axis_tuser), s_axis_tdata[0],
                                                   s_axis_tdata[1], s_axis_tdata[2 +: MEAS_W]));
      items_taken++;
    end
    if (rst_ni && psel && penable && pwrite && pready && paddr == ADDR_SCALE)
      scale_m = pwdata[SCALE_W-1:0];
  end

  // Compare results and drive the output stall pattern
  int hold_served;
  int hold_left;
  always @(posedge clk_i) begin
    reading_t want;
    reading_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      readings_seen++;
      got.dac      = m_axis_tdata[DAC_W-1:0];
      got.setpoint = m_axis_tdata[DAC_W +: SP_W];
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result dac=%0d setpoint=%0d", $realtime, got.dac,
                   got.setpoint);
      end else begin
        want = pending_readings.pop_front();
        if (got.dac != want.dac || got.setpoint != want.setpoint) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d: dac exp %0d got %0d, setpoint exp %0d got %0d",
                     $realtime, readings_seen, want.dac, got.dac, want.setpoint,
                     got.setpoint);
        end
      end
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Abort when nothing moves for too long
  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(input action_e act, input logic pin_a, input logic pin_b,
                           input logic [MEAS_W-1:0] ma);
    int gap;
    gap = 0;
    // Idle each cycle with the given chance before offering the item
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(IN_DATA_W - MEAS_W - 2){1'b0}}, ma, pin_b, pin_a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic detent_up();
    send_item(ACT_PIN_A, 1'b0, 1'b1, MEAS_W'($urandom_range(0, MEAS_TOP)));
    send_item(ACT_PIN_B, 1'b0, 1'b0, MEAS_W'($urandom_range(0, MEAS_TOP)));
  endtask

  task automatic detent_down();
    send_item(ACT_PIN_B, 1'b1, 1'b0, MEAS_W'($urandom_range(0, MEAS_TOP)));
    send_item(ACT_PIN_A, 1'b0, 1'b0, MEAS_W'($urandom_range(0, MEAS_TOP)));
  endtask

  // Drop valid and let every outstanding result drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    wait (pending_readings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [CFG_DATA_W-1:0] value);
    settle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_SCALE;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scale_writes++;
  endtask

  task automatic check_scale_readback();
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_SCALE;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    readbacks++;
    if (prdata[SCALE_W-1:0] != scale_m) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: scale readback exp %0d got %0d", $realtime, scale_m,
                 prdata[SCALE_W-1:0]);
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    check_scale_readback();
    // Idle action before any tick: drive code still at its reset value
    send_item(ACT_NONE, 1'b1, 1'b1, 16'hFFFF);
    send_item(ACT_PIN_A, 1'b1, 1'b1, 16'h0000);
    // Step down at zero: setpoint holds, flags clear
    send_item(ACT_PIN_B, 1'b1, 1'b0, 16'h5A5A);
    send_item(ACT_PIN_A, 1'b0, 1'b0, 16'hA5A5);
    // Tick with zero setpoint forces the drive code to zero
    send_item(ACT_TICK, 1'b0, 1'b0, 16'h0000);
    detent_up();
    send_item(ACT_TICK, 1'b1, 1'b1, 16'd0);
    // Current equal to the target holds the code
    send_item(ACT_TICK, 1'b0, 1'b1, 16'd1000);
    send_item(ACT_TICK, 1'b1, 1'b0, 16'hFFFF);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'hFFFF);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd999);
    // Both flags armed, then the pin B close steps up
    send_item(ACT_PIN_B, 1'b1, 1'b0, 16'h0001);
    send_item(ACT_PIN_A, 1'b0, 1'b1, 16'h8000);
    send_item(ACT_PIN_B, 1'b0, 1'b0, 16'h7FFF);
    send_item(ACT_PIN_A, 1'b0, 1'b0, 16'h0000);
    send_item(ACT_PIN_B, 1'b1, 1'b1, 16'h1234);
    send_item(ACT_NONE, 1'b0, 1'b0, MEAS_W'($urandom_range(0, MEAS_TOP)));
  endtask

  task automatic test_scale_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Zero scale gives a zero target
    write_scale('0);
    check_scale_readback();
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd0);
    send_item(ACT_TICK, 1'b1, 1'b1, 16'd1);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd0);
    write_scale(CFG_DATA_W'(DAC_TOP));
    check_scale_readback();
    send_item(ACT_TICK, 1'b0, 1'b0, 16'hFFFF);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd8190);
    write_scale(32'd1);
    check_scale_readback();
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd2);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd1);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd0);
    // Only the low bits of the write land in the register
    write_scale(32'hFFFF_F7D0);
    check_scale_readback();
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd4000);
  endtask

  task automatic test_rails();
    int downs;
    send_idle_pct  = 0;
    recv_stall_pct = 10;
    write_scale(CFG_DATA_W'(DAC_TOP));
    // Walk the setpoint down past zero: it holds at the bottom
    downs = int'(setpoint_m) + 1;
    repeat (downs) detent_down();
    // Zero setpoint puts the code on the bottom rail
    send_item(ACT_TICK, 1'b1, 1'b1, 16'd0);
    detent_up();
    // Current above the target with the code at zero: the code stays there
    send_item(ACT_TICK, 1'b0, 1'b0, 16'hFFFF);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd0);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'd0);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'hFFFF);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'hFFFF);
    send_item(ACT_TICK, 1'b0, 1'b0, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int sent;
    int pick;
    int target_ma;
    send_idle_pct  = 0;
    recv_stall_pct = stall_pct;
    write_scale(CFG_DATA_W'($urandom_range(1, 255)));
    send_idle_pct = idle_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
        detent_up();
        sent += 2;
      end else if (pick < 42) begin
        detent_down();
        sent += 2;
      end else begin
        if (pick < 72) begin
          // Current close to the target, so the code moves both ways and holds
          target_ma = int'(setpoint_m) * int'(scale_m) + $urandom_range(0, 6) - 3;
          if (target_ma < 0) target_ma = 0;
          if (target_ma > MEAS_TOP) target_ma = MEAS_TOP;
          send_item(ACT_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    MEAS_W'(target_ma));
        end else if (pick < 82) begin
          send_item(ACT_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    MEAS_W'($urandom_range(0, MEAS_TOP)));
        end else begin
          send_item(action_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), MEAS_W'($urandom_range(0, MEAS_TOP)));
        end
        sent++;
      end
    end
  endtask

  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    // Receiver holds off while items keep coming: the block fills and stalls
    hold_requests++;
    repeat (15) detent_up();
    repeat (10) send_item(ACT_TICK, 1'b0, 1'b0, MEAS_W'($urandom_range(0, MEAS_TOP)));
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_NONE;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_scale_extremes();
    test_rails();
    test_random_traffic(0, 0, 80);
    test_random_traffic(49, 0, 80);
    test_random_traffic(0, 49, 80);
    test_random_traffic(18, 18, 80);
    test_output_hold_off();
    settle();

    $display("covered %0d input transactions, %0d results, %0d scale writes, %0d readbacks",
             items_taken, readings_seen, scale_writes, readbacks);
    $display("edge and tick corner cases, scale extremes, setpoint and drive code floors,"
             , " four idling phases, long output hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[encoder_setpoint_dac_step_regulator_top.f]
sv/esdr_pkg.sv
sv/esdr_step.sv
sv/encoder_setpoint_dac_step_regulator_top.sv
tb/tb_encoder_setpoint_dac_step_regulator_top.sv
